@@ hdl/twsm_pkg.sv @@
// Shared types and constants for the three-wire LSB-first serial master.
// No dependencies; imported by the top level, the front end, the queue and the sequencer.
package twsm_pkg;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned COUNT_W     = 4;
  localparam int unsigned BIT_STEP_W  = 4;

  localparam logic [COUNT_W-1:0]    MAX_DATA_BYTES = 4'd10;
  localparam logic [BYTE_W-1:0]     KEY_READ_RESET = 8'd66;
  localparam logic [BIT_STEP_W-1:0] LAST_BIT_STEP  = 4'd15;

  typedef enum logic [1:0] {
    MODE_CMD  = 2'd0,
    MODE_DATA = 2'd1,
    MODE_READ = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    TAIL_NONE,
    TAIL_CLOSE,
    TAIL_RELEASE,
    TAIL_KEY
  } tail_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_HEAD,
    BK_BITS,
    BK_TAIL
  } back_state_t;

  // one word of bus work, as decided by the front
  typedef struct packed {
    logic              has_head;
    logic              head_data;
    logic              shift;
    logic              bits_strobe;
    logic              bits_drive;
    logic [BYTE_W-1:0] byte_val;
    tail_t             tail;
    logic              tail_data;
  } job_t;

  typedef struct packed {
    logic              strobe;
    logic              clock;
    logic              data;
    logic              drive;
    logic [BYTE_W-1:0] key;
    logic              valid;
    logic              last;
  } step_t;

endpackage

@@ hdl/three_wire_lsb_serial_master.sv @@
// Three-wire LSB-first serial master: each input word yields up to 18 pin-step words.
// Pin steps are paced by the sequencer's step timer and wait while the output is stalled;
// a two-entry job queue keeps the input open while the sequencer plays a job, until the
// queue is full.
// Reset (rst, synchronous): strobe idle high, data line high, key-read command 66, queue empty.
module three_wire_lsb_serial_master #(
  parameter int unsigned HALF_BIT_CYCLES     = 50,
  parameter int unsigned STROBE_SETUP_CYCLES = 50
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wen,
  input  logic [7:0]  cfg_wdata,      // key_read_command
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // byte_value[7:0], panel_bits[15:8]
  input  logic [1:0]  s_axis_tuser,   // mode
  input  logic        s_axis_tlast,   // end_of_frame
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // strobe, clock, data, driven, key_code[11:4], zero pad
  output logic        m_axis_tuser,   // key_valid
  output logic        m_axis_tlast    // last_step
);
  import twsm_pkg::*;

  logic  q_push, q_pop, q_full, q_empty;
  job_t  push_job, pop_job;
  step_t step;

  twsm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_mode   (s_axis_tuser),
    .in_byte   (s_axis_tdata[7:0]),
    .in_eof    (s_axis_tlast),
    .in_panel  (s_axis_tdata[15:8]),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_job     (push_job)
  );

  twsm_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .pop_job  (pop_job)
  );

  twsm_back #(
    .HALF_BIT_CYCLES     (HALF_BIT_CYCLES),
    .STROBE_SETUP_CYCLES (STROBE_SETUP_CYCLES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_job     (pop_job),
    .q_pop     (q_pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_step  (step)
  );

  assign m_axis_tdata = {4'b0000, step.key, step.drive, step.data, step.clock, step.strobe};
  assign m_axis_tuser = step.valid;
  assign m_axis_tlast = step.last;

endmodule

@@ hdl/twsm_front.sv @@
// Front end: accepts words, tracks frame state and builds bus jobs.
// Depends on twsm_pkg.
module twsm_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wen,
  input  logic [7:0]             cfg_wdata,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [1:0]             in_mode,
  input  logic [7:0]             in_byte,
  input  logic                   in_eof,
  input  logic [7:0]             in_panel,
  input  logic                   q_full,
  output logic                   q_push,
  output twsm_pkg::job_t         q_job
);
  import twsm_pkg::*;

  logic [BYTE_W-1:0]  key_read_command;
  logic               strobe_state, strobe_state_next;
  logic               frame_reads_keys, frame_reads_keys_next;
  logic [COUNT_W-1:0] frame_byte_count, frame_byte_count_next;
  logic               data_line_state, data_line_state_next;
  logic               accept;
  logic               job_ok;
  job_t               job;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign q_push   = accept && job_ok;
  assign q_job    = job;

  always_comb begin
    job                   = '0;
    job.tail              = TAIL_NONE;
    job_ok                = 1'b0;
    strobe_state_next     = strobe_state;
    frame_reads_keys_next = frame_reads_keys;
    frame_byte_count_next = frame_byte_count;
    data_line_state_next  = data_line_state;
    unique case (mode_t'(in_mode))
      MODE_CMD: begin
        job_ok                = 1'b1;
        job.has_head          = 1'b1;
        job.head_data         = data_line_state;
        job.shift             = 1'b1;
        job.bits_strobe       = 1'b0;
        job.bits_drive        = 1'b1;
        job.byte_val          = in_byte;
        job.tail_data         = in_byte[BYTE_W-1];
        strobe_state_next     = 1'b0;
        frame_byte_count_next = '0;
        frame_reads_keys_next = (in_byte == key_read_command);
        data_line_state_next  = in_byte[BYTE_W-1];
        if (in_eof) begin
          if (in_byte == key_read_command) begin
            job.tail             = TAIL_RELEASE;
            data_line_state_next = 1'b1;
          end else begin
            job.tail          = TAIL_CLOSE;
            strobe_state_next = 1'b1;
          end
        end
      end
      MODE_DATA: begin
        if (!strobe_state) begin
          job.bits_strobe = 1'b0;
          job.bits_drive  = 1'b1;
          job.byte_val    = in_byte;
          job.tail_data   = data_line_state;
          if (frame_byte_count < MAX_DATA_BYTES) begin
            job_ok                = 1'b1;
            job.shift             = 1'b1;
            job.tail_data         = in_byte[BYTE_W-1];
            frame_byte_count_next = frame_byte_count + 4'd1;
            data_line_state_next  = in_byte[BYTE_W-1];
          end
          if (in_eof) begin
            frame_byte_count_next = '0;
            if (!frame_reads_keys) begin
              job_ok            = 1'b1;
              job.tail          = TAIL_CLOSE;
              strobe_state_next = 1'b1;
            end
          end
        end
      end
      MODE_READ: begin
        job_ok                = 1'b1;
        job.shift             = 1'b1;
        job.bits_strobe       = strobe_state;
        job.bits_drive        = 1'b0;
        job.byte_val          = in_panel;
        job.tail              = TAIL_KEY;
        job.tail_data         = 1'b1;
        strobe_state_next     = 1'b1;
        frame_reads_keys_next = 1'b0;
        frame_byte_count_next = '0;
        data_line_state_next  = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_read_command <= KEY_READ_RESET;
      strobe_state     <= 1'b1;
      frame_reads_keys <= 1'b0;
      frame_byte_count <= '0;
      data_line_state  <= 1'b1;
    end else begin
      if (cfg_wen) begin
        key_read_command <= cfg_wdata;
      end
      if (accept) begin
        strobe_state     <= strobe_state_next;
        frame_reads_keys <= frame_reads_keys_next;
        frame_byte_count <= frame_byte_count_next;
        data_line_state  <= data_line_state_next;
      end
    end
  end

endmodule

@@ hdl/twsm_queue.sv @@
// Two-entry job queue between the front end and the bus sequencer.
// Depends on twsm_pkg.
module twsm_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  twsm_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output twsm_pkg::job_t pop_job
);
  import twsm_pkg::*;

  job_t       entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign full    = (fill == 2'd2);
  assign empty   = (fill == 2'd0);
  assign pop_job = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: ;
      endcase
    end
  end

endmodule

@@ hdl/twsm_back.sv @@
// Bus sequencer: plays one job as timed pin steps into an output register.
// Depends on twsm_pkg.
module twsm_back #(
  parameter int unsigned HALF_BIT_CYCLES     = 50,
  parameter int unsigned STROBE_SETUP_CYCLES = 50
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_empty,
  input  twsm_pkg::job_t q_job,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_ready,
  output twsm_pkg::step_t out_step
);
  import twsm_pkg::*;

  localparam int unsigned MAX_DELAY =
    (HALF_BIT_CYCLES > STROBE_SETUP_CYCLES) ? HALF_BIT_CYCLES : STROBE_SETUP_CYCLES;
  localparam int unsigned TIMER_W = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;
  localparam logic [TIMER_W-1:0] BIT_RELOAD    = TIMER_W'(HALF_BIT_CYCLES - 1);
  localparam logic [TIMER_W-1:0] STROBE_RELOAD = TIMER_W'(STROBE_SETUP_CYCLES - 1);

  back_state_t            state, state_next;
  job_t                   job;
  logic [BIT_STEP_W-1:0]  idx;
  logic [TIMER_W-1:0]     timer;
  logic                   out_free;
  logic                   fire;
  step_t                  step;

  assign out_free = !out_valid || out_ready;
  assign q_pop    = (state == BK_IDLE) && !q_empty;
  assign fire     = (state != BK_IDLE) && (timer == '0) && out_free;

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (!q_empty) begin
          if (q_job.has_head) begin
            state_next = BK_HEAD;
          end else if (q_job.shift) begin
            state_next = BK_BITS;
          end else begin
            state_next = BK_TAIL;
          end
        end
      end
      BK_HEAD: begin
        if (fire) begin
          state_next = job.shift ? BK_BITS : BK_TAIL;
        end
      end
      BK_BITS: begin
        if (fire && idx == LAST_BIT_STEP) begin
          state_next = (job.tail == TAIL_NONE) ? BK_IDLE : BK_TAIL;
        end
      end
      BK_TAIL: begin
        if (fire) begin
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    step = '0;
    unique case (state)
      BK_HEAD: begin
        step.strobe = 1'b0;
        step.clock  = 1'b1;
        step.data   = job.head_data;
        step.drive  = 1'b1;
      end
      BK_BITS: begin
        step.strobe = job.bits_strobe;
        step.clock  = idx[0];
        step.data   = job.byte_val[idx[BIT_STEP_W-1:1]];
        step.drive  = job.bits_drive;
        step.last   = (idx == LAST_BIT_STEP) && (job.tail == TAIL_NONE);
      end
      BK_TAIL: begin
        step.clock = 1'b1;
        step.last  = 1'b1;
        unique case (job.tail)
          TAIL_CLOSE: begin
            step.strobe = 1'b1;
            step.data   = job.tail_data;
            step.drive  = 1'b1;
          end
          TAIL_RELEASE: begin
            step.strobe = 1'b0;
            step.data   = 1'b1;
            step.drive  = 1'b0;
          end
          TAIL_KEY: begin
            step.strobe = 1'b1;
            step.data   = 1'b1;
            step.drive  = 1'b0;
            step.key    = job.byte_val;
            step.valid  = 1'b1;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      job <= q_job;
    end
    if (fire) begin
      out_step <= step;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      idx       <= '0;
      timer     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (q_pop) begin
        idx <= '0;
      end else if (fire && state == BK_BITS) begin
        idx <= idx + 4'd1;
      end
      if (q_pop || fire) begin
        timer <= (state_next == BK_BITS) ? BIT_RELOAD : STROBE_RELOAD;
      end else if (state != BK_IDLE && timer != '0) begin
        timer <= timer - TIMER_W'(1);
      end
      if (fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ hdl/twsm_checker.sv @@
// Port-level checks for the three-wire serial master, bound to the top level.
// Depends only on the top level's ports.
module twsm_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        m_axis_tuser,
  input logic        m_axis_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
      && $stable(m_axis_tlast))
    else $error("output word changed while stalled");

  a_key_is_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
    else $error("key word not marked last");

  a_key_pins: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |->
      m_axis_tdata[0] && m_axis_tdata[1] && m_axis_tdata[2] && !m_axis_tdata[3])
    else $error("key word with wrong pin levels");

  a_code_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[11:4] == 8'd0)
    else $error("key code on a non-key word");

endmodule

bind three_wire_lsb_serial_master twsm_checker u_twsm_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

@@ test/testbench.sv @@
// Self-checking bench for three_wire_lsb_serial_master: frames, reads, overflow and noise.
// Drives both stream sides with random stalls and predicts every pin-step word.
// Depends on hdl/twsm_pkg.sv and hdl/three_wire_lsb_serial_master.sv.
`timescale 1ns / 100ps

module testbench;
  import twsm_pkg::*;

  localparam logic [1:0] MODE_UNUSED  = 2'd3;
  localparam int SETTLE_CYCLES        = 300;
  localparam int TOTAL_WORDS          = 470;
  localparam int CALM_AFTER           = 400;

  class pin_step_board;
    step_t       expected_steps[$];
    logic [7:0]  key_cmd;
    logic        strobe_q;
    logic        key_frame;
    logic [3:0]  byte_cnt;
    logic        data_q;
    int          mismatches;
    int          steps_checked;
    int          keys_read;

    function new();
      key_cmd       = KEY_READ_RESET;
      strobe_q      = 1'b1;
      key_frame     = 1'b0;
      byte_cnt      = '0;
      data_q        = 1'b1;
      mismatches    = 0;
      steps_checked = 0;
      keys_read     = 0;
    endfunction

    function int pending();
      return expected_steps.size();
    endfunction

    function void push(logic s, logic c, logic d, logic drv, logic [7:0] key, logic vld);
      step_t st;
      st.strobe = s;
      st.clock  = c;
      st.data   = d;
      st.drive  = drv;
      st.key    = key;
      st.valid  = vld;
      st.last   = 1'b0;
      expected_steps.push_back(st);
    endfunction

    function void shift_out(logic [7:0] val);
      for (int i = 0; i < 8; i++) begin
        push(strobe_q, 1'b0, val[i], 1'b1, 8'h00, 1'b0);
        push(strobe_q, 1'b1, val[i], 1'b1, 8'h00, 1'b0);
        data_q = val[i];
      end
    endfunction

    function void close_frame();
      if (!key_frame) begin
        strobe_q = 1'b1;
        push(1'b1, 1'b1, data_q, 1'b1, 8'h00, 1'b0);
      end
      byte_cnt = '0;
    endfunction

    // returns the number of pin steps this word causes
    function int note_input(logic [1:0] mode, logic [7:0] val, logic eof, logic [7:0] panel);
      int    start_size;
      int    n;
      step_t st;
      start_size = expected_steps.size();
      if (mode == MODE_CMD) begin
        strobe_q  = 1'b0;
        byte_cnt  = '0;
        key_frame = (val == key_cmd);
        push(1'b0, 1'b1, data_q, 1'b1, 8'h00, 1'b0);
        shift_out(val);
        if (eof) begin
          if (key_frame) begin
            data_q = 1'b1;
            push(1'b0, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0);
            byte_cnt = '0;
          end else begin
            close_frame();
          end
        end
      end else if (mode == MODE_DATA) begin
        if (!strobe_q) begin
          if (byte_cnt < MAX_DATA_BYTES) begin
            byte_cnt = byte_cnt + 4'd1;
            shift_out(val);
          end
          if (eof) close_frame();
        end
      end else if (mode == MODE_READ) begin
        for (int i = 0; i < 8; i++) begin
          push(strobe_q, 1'b0, panel[i], 1'b0, 8'h00, 1'b0);
          push(strobe_q, 1'b1, panel[i], 1'b0, 8'h00, 1'b0);
        end
        strobe_q  = 1'b1;
        key_frame = 1'b0;
        byte_cnt  = '0;
        data_q    = 1'b1;
        push(1'b1, 1'b1, 1'b1, 1'b0, panel, 1'b1);
        keys_read++;
      end
      n = expected_steps.size() - start_size;
      if (n > 0) begin
        st = expected_steps[expected_steps.size() - 1];
        st.last = 1'b1;
        expected_steps[expected_steps.size() - 1] = st;
      end
      return n;
    endfunction

    function void check_step(logic [15:0] tdata, logic tuser, logic tlast);
      step_t want;
      step_t got;
      got.strobe = tdata[0];
      got.clock  = tdata[1];
      got.data   = tdata[2];
      got.drive  = tdata[3];
      got.key    = tdata[11:4];
      got.valid  = tuser;
      got.last   = tlast;
      steps_checked++;
      if (expected_steps.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] extra word stb=%0b clk=%0b dat=%0b drv=%0b key=%02h vld=%0b last=%0b",
                   $realtime, got.strobe, got.clock, got.data, got.drive, got.key, got.valid,
                   got.last);
        return;
      end
      want = expected_steps.pop_front();
      if (got.strobe !== want.strobe || got.clock !== want.clock || got.data !== want.data ||
          got.drive !== want.drive || got.key !== want.key || got.valid !== want.valid ||
          got.last !== want.last) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("[%0t] step word mismatch", $realtime);
          $display("  expected stb=%0b clk=%0b dat=%0b drv=%0b key=%02h vld=%0b last=%0b",
                   want.strobe, want.clock, want.data, want.drive, want.key, want.valid,
                   want.last);
          $display("  actual   stb=%0b clk=%0b dat=%0b drv=%0b key=%02h vld=%0b last=%0b",
                   got.strobe, got.clock, got.data, got.drive, got.key, got.valid, got.last);
        end
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_wen;
  logic [7:0]  cfg_wdata;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;

  pin_step_board sb = new();
  int            words_done = 0;
  int            settings_used = 0;
  int            stall_left = 0;
  bit            bursts_on = 1'b1;

  three_wire_lsb_serial_master i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wen       (cfg_wen),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("timeout with %0d step words outstanding", sb.pending());
    $display("Verification failed");
    $finish;
  end

  // result side: random stall bursts, check every accepted word
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) sb.check_step(m_axis_tdata, m_axis_tuser, m_axis_tlast);
      if (stall_left > 0) begin
        stall_left    <= stall_left - 1;
        m_axis_tready <= 1'b0;
      end else if (bursts_on && $urandom_range(0, 11) == 0) begin
        stall_left    <= $urandom_range(0, 17);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  function automatic logic [7:0] rnd8();
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_word(input logic [1:0] mode, input logic [7:0] val, input logic eof,
                           input logic [7:0] panel);
    if (bursts_on && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {panel, val};
    s_axis_tuser  <= mode;
    s_axis_tlast  <= eof;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    if (sb.note_input(mode, val, eof, panel) > 0) words_done++;
  endtask

  // sender holds off until every step word is back, then lets the sequencer settle
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_key_cmd(input logic [7:0] value);
    drain();
    cfg_wen   <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wen   <= 1'b0;
    sb.key_cmd = value;
    settings_used++;
  endtask

  task automatic random_frame();
    int         kind;
    int         nbytes;
    logic [7:0] cmd;
    kind = $urandom_range(0, 99);
    if (kind < 55) begin
      cmd    = rnd8();
      nbytes = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 13) : $urandom_range(0, 4);
      send_word(MODE_CMD, cmd, nbytes == 0, rnd8());
      for (int i = 1; i <= nbytes; i++) send_word(MODE_DATA, rnd8(), i == nbytes, rnd8());
      if ($urandom_range(0, 3) == 0)
        send_word(MODE_READ, rnd8(), 1'($urandom_range(0, 1)), rnd8());
    end else if (kind < 75) begin
      nbytes = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
      send_word(MODE_CMD, sb.key_cmd, nbytes == 0, rnd8());
      for (int i = 1; i <= nbytes; i++) send_word(MODE_DATA, rnd8(), i == nbytes, rnd8());
      send_word(MODE_READ, rnd8(), 1'($urandom_range(0, 1)), rnd8());
    end else if (kind < 85) begin
      send_word(MODE_READ, rnd8(), 1'($urandom_range(0, 1)), rnd8());
    end else begin
      send_word(2'($urandom_range(0, 3)), rnd8(), 1'($urandom_range(0, 1)), rnd8());
    end
  endtask

  task automatic random_run(input int upto);
    while (words_done < upto) begin
      bursts_on = (words_done < CALM_AFTER);
      random_frame();
    end
  endtask

  initial begin
    rst           = 1'b1;
    cfg_wen       = 1'b0;
    cfg_wdata     = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = MODE_CMD;
    s_axis_tlast  = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: plain frame, extremes, ignored words, key-read frames, reads, overflow
    send_word(MODE_CMD, 8'hFF, 1'b0, 8'h00);
    send_word(MODE_DATA, 8'h00, 1'b0, 8'hFF);
    send_word(MODE_DATA, 8'hFF, 1'b1, 8'h00);
    send_word(MODE_CMD, 8'h00, 1'b1, 8'hFF);
    send_word(MODE_DATA, 8'hA5, 1'b1, 8'h5A);
    send_word(MODE_UNUSED, 8'h3C, 1'b1, 8'hC3);
    send_word(MODE_CMD, KEY_READ_RESET, 1'b1, 8'h00);
    send_word(MODE_READ, 8'h00, 1'b0, 8'hA5);
    send_word(MODE_READ, 8'hFF, 1'b1, 8'hFF);
    send_word(MODE_CMD, KEY_READ_RESET, 1'b0, 8'h00);
    send_word(MODE_DATA, 8'h12, 1'b1, 8'h00);
    send_word(MODE_READ, 8'h00, 1'b0, 8'h00);
    send_word(MODE_CMD, 8'h33, 1'b0, 8'h00);
    send_word(MODE_CMD, 8'h44, 1'b1, 8'h00);
    send_word(MODE_CMD, 8'h10, 1'b0, 8'h00);
    for (int i = 1; i <= 11; i++) send_word(MODE_DATA, rnd8(), i == 11, rnd8());

    write_key_cmd(8'h00);
    random_run(140);
    write_key_cmd(8'hFF);
    random_run(240);
    write_key_cmd(rnd8());
    random_run(340);
    write_key_cmd(KEY_READ_RESET);
    random_run(TOTAL_WORDS);
    drain();

    $display("%0d words with bus activity, %0d step words checked, %0d key reads",
             words_done, sb.steps_checked, sb.keys_read);
    $display("%0d key-read command settings written, %0d mismatches",
             settings_used, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
